// ===== hw/rtl/lu_solve_scaled_pivot_top_macros.svh =====
// assertion helpers for the scaled pivot solver
`ifndef LU_SOLVE_SCALED_PIVOT_TOP_MACROS_SVH
`define LU_SOLVE_SCALED_PIVOT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LUSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LUSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LUSP_ASSERT_IMP(lbl, ante, cons, msg)
`define LUSP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/lusp_pkg.sv =====
`default_nettype none
package lusp_pkg;

  // operation codes of an input word
  localparam logic [1:0] MODE_MAT   = 2'd0;
  localparam logic [1:0] MODE_RHS   = 2'd1;
  localparam logic [1:0] MODE_SOLVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_ROW   = 2'd1;
  localparam logic [1:0] ST_ZERO_COL   = 2'd2;
  localparam logic [1:0] ST_ZERO_PIVOT = 2'd3;

  localparam int ORDER_W = 5;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         fail_index;
    logic [3:0]         sol_index;
    logic signed [31:0] solution_value;
    logic               last;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lu_solve_scaled_pivot_top.sv =====
`default_nettype none
`include "lu_solve_scaled_pivot_top_macros.svh"
// Linear system solver, Q16.16, LU with row-scaled partial pivoting.
// Input channel (in_valid / in_stall / in_data): load words write one matrix
// element or one right-hand element and are taken one per cycle while idle.
// A start word runs the solve; in_stall stays high until its last result
// word has been placed in the output register.
// Output channel (out_valid / out_stall / out_data): n solution words x[0]
// .. x[n-1] with last on x[n-1], or one status word with last set when a
// zero row, zero pivot column or zero final pivot is found.
// Configuration (cfg_valid / cfg_ready / cfg_data): the order n, taken when
// the block is idle. Reset sets n to 16 and leaves no result pending.
// A solve runs row scaling, then per pivot column k a pivot search and the
// elimination of each remaining row, then forward sums and back
// substitution, in turn, sharing one 33x33 multiplier, one radix-2 divider
// and the single read port of the matrix memory.
// A stalled output holds its word; the block waits before the next result.
module lu_solve_scaled_pivot_top import lusp_pkg::*; #(
  parameter int MAX_ORDER = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [ORDER_W-1:0] cfg_data
);

  localparam int IW        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW        = $clog2(MAX_ORDER + 1);
  localparam int AW        = 2 * IW;
  localparam int A_DEPTH   = 1 << AW;
  localparam int DIV_STEPS = 48;
  localparam int DCW       = 6;

  typedef enum logic [36:0] {
    S_IDLE   = 37'd1 << 0,
    S_SC_RD  = 37'd1 << 1,
    S_SC_USE = 37'd1 << 2,
    S_PV_RD  = 37'd1 << 3,
    S_PV_USE = 37'd1 << 4,
    S_CD_RD  = 37'd1 << 5,
    S_CD_M1  = 37'd1 << 6,
    S_CD_M2  = 37'd1 << 7,
    S_CD_CMP = 37'd1 << 8,
    S_PV_CHK = 37'd1 << 9,
    S_SW1    = 37'd1 << 10,
    S_SW2    = 37'd1 << 11,
    S_PK_RD  = 37'd1 << 12,
    S_PK_USE = 37'd1 << 13,
    S_EL_RD  = 37'd1 << 14,
    S_EL_DIV = 37'd1 << 15,
    S_EL_DW  = 37'd1 << 16,
    S_EU_RD  = 37'd1 << 17,
    S_EU_M   = 37'd1 << 18,
    S_EU_RD2 = 37'd1 << 19,
    S_EU_WR  = 37'd1 << 20,
    S_FP_RD  = 37'd1 << 21,
    S_FP_USE = 37'd1 << 22,
    S_FW_RD  = 37'd1 << 23,
    S_FW_RHS = 37'd1 << 24,
    S_SUM_RD = 37'd1 << 25,
    S_SUM_M  = 37'd1 << 26,
    S_SUM_AC = 37'd1 << 27,
    S_FW_WR  = 37'd1 << 28,
    S_BW_RD  = 37'd1 << 29,
    S_BW_X   = 37'd1 << 30,
    S_BW_DG  = 37'd1 << 31,
    S_BW_DIV = 37'd1 << 32,
    S_BW_DW  = 37'd1 << 33,
    S_EM_RD  = 37'd1 << 34,
    S_EM_OUT = 37'd1 << 35,
    S_FAIL   = 37'd1 << 36
  } state_t;

  // magnitude of a signed word, -2^31 gives 2^31
  function automatic logic [31:0] magn(input logic signed [31:0] v);
    magn = v[31] ? (~v + 32'd1) : v;
  endfunction

  // q16 product truncated toward zero
  function automatic logic signed [63:0] qprod(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    qprod = adj >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

  state_t state_r, state_nxt;

  logic [ORDER_W-1:0] order_r;
  logic [CW-1:0]      n_r, n_nxt, n_start, nm1;
  logic [CW-1:0]      i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, best_r, best_nxt;
  logic [CW-1:0]      i_inc, j_inc, k_inc, piv_idx;
  logic [31:0]        m_r, m_nxt, m_cand, bm_r, bm_nxt, bs_r, bs_nxt;
  logic [31:0]        cm_r, cm_nxt, cs_r, cs_nxt;
  logic [IW-1:0]      r_r, r_nxt, pr_r, pr_nxt, tmp_r, tmp_nxt, piv_q;
  logic signed [31:0] pv_r, pv_nxt, f_r, f_nxt, b_r, b_nxt;
  logic signed [63:0] s_r, s_nxt;
  logic [63:0]        prod1_r, prod1_nxt;
  logic [1:0]         code_r, code_nxt;
  logic [4:0]         where_r, where_nxt;
  logic               bwd_r, bwd_nxt;

  // pivot order, identity after reset
  logic [IW-1:0] piv_r [MAX_ORDER];

  // memories
  logic signed [31:0] a_mem [A_DEPTH];
  logic signed [31:0] rhs_mem [MAX_ORDER];
  logic [31:0]        scale_mem [MAX_ORDER];
  logic signed [31:0] x_mem [MAX_ORDER];
  logic signed [31:0] a_rd_r, rhs_rd_r, x_rd_r;
  logic [31:0]        scale_rd_r;
  logic [IW-1:0]      a_rrow, a_rcol, a_wrow, a_wcol, x_raddr;
  logic               a_we, x_we, scale_we, rhs_we;
  logic signed [31:0] a_wdata, x_wdata;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] mul_r;

  // shared divider
  logic               div_start;
  logic signed [31:0] div_num, div_den;
  logic [DCW-1:0]     div_cnt_r;
  logic [47:0]        div_q_r;
  logic [31:0]        div_rem_r, div_den_r;
  logic               div_neg_r, div_zero_r;
  logic [32:0]        div_sh;
  logic               div_ge;
  logic signed [31:0] div_res;

  logic signed [31:0] fw_val, bw_num, eu_val;
  logic               in_acc, out_free, out_load, out_valid_r;
  out_item_t          out_data_r, out_item_nxt;

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // order clamp
  always_comb begin
    if (order_r == '0) n_start = CW'(1);
    else if (32'(order_r) > 32'(MAX_ORDER)) n_start = CW'(MAX_ORDER);
    else n_start = CW'(order_r);
  end

  assign nm1   = n_r - CW'(1);
  assign i_inc = i_r + CW'(1);
  assign j_inc = j_r + CW'(1);
  assign k_inc = k_r + CW'(1);

  // pivot order read, one place per cycle
  always_comb begin
    unique case (state_r)
      S_CD_RD, S_EL_RD: piv_idx = i_r;
      S_SW1:            piv_idx = best_r;
      S_FP_RD:          piv_idx = nm1;
      default:          piv_idx = k_r;
    endcase
  end
  assign piv_q = piv_r[piv_idx[IW-1:0]];

  // matrix read address
  always_comb begin
    unique case (state_r)
      S_PV_RD, S_CD_RD, S_EL_RD: begin
        a_rrow = piv_q;
        a_rcol = k_r[IW-1:0];
      end
      S_PK_RD: begin
        a_rrow = pr_r;
        a_rcol = k_r[IW-1:0];
      end
      S_EU_RD: begin
        a_rrow = pr_r;
        a_rcol = j_r[IW-1:0];
      end
      S_EU_RD2, S_SUM_RD: begin
        a_rrow = r_r;
        a_rcol = j_r[IW-1:0];
      end
      S_FP_RD: begin
        a_rrow = piv_q;
        a_rcol = nm1[IW-1:0];
      end
      S_BW_DG: begin
        a_rrow = r_r;
        a_rcol = k_r[IW-1:0];
      end
      default: begin
        a_rrow = i_r[IW-1:0];
        a_rcol = j_r[IW-1:0];
      end
    endcase
  end

  assign x_raddr = (state_r == S_SUM_RD) ? j_r[IW-1:0] : k_r[IW-1:0];

  // arithmetic results used in several states
  assign m_cand = (magn(a_rd_r) > m_r) ? magn(a_rd_r) : m_r;
  assign fw_val = sat32(66'(b_r) - 66'(s_r));
  assign bw_num = fw_val;
  assign eu_val = sat32(66'(a_rd_r) - 66'($signed(prod1_r)));

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      S_CD_M1: begin
        mul_a = $signed({1'b0, magn(a_rd_r)});
        mul_b = $signed({1'b0, bs_r});
      end
      S_CD_M2: begin
        mul_a = $signed({1'b0, bm_r});
        mul_b = $signed({1'b0, cs_r});
      end
      S_EU_M: begin
        mul_a = 33'(f_r);
        mul_b = 33'(a_rd_r);
      end
      default: begin
        mul_a = 33'(a_rd_r);
        mul_b = 33'(x_rd_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= 64'(mul_a * mul_b);
  end

  // divider, one quotient bit a cycle
  assign div_start = (state_r == S_EL_DIV) || (state_r == S_BW_DIV);
  assign div_num   = (state_r == S_EL_DIV) ? a_rd_r : bw_num;
  assign div_den   = (state_r == S_EL_DIV) ? pv_r : a_rd_r;
  assign div_sh    = {div_rem_r, div_q_r[47]};
  assign div_ge    = div_sh >= {1'b0, div_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_start) begin
      div_cnt_r <= DCW'(DIV_STEPS);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_q_r    <= {magn(div_num), 16'd0};
      div_rem_r  <= '0;
      div_den_r  <= magn(div_den);
      div_neg_r  <= div_num[31] ^ div_den[31];
      div_zero_r <= (div_den == '0);
    end else if (div_cnt_r != '0) begin
      div_rem_r <= div_ge ? 32'(div_sh - {1'b0, div_den_r}) : div_sh[31:0];
      div_q_r   <= {div_q_r[46:0], div_ge};
    end
  end

  // signed, saturated quotient
  always_comb begin
    if (div_zero_r) div_res = '0;
    else if (!div_neg_r) div_res = (div_q_r > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q_r[31:0];
    else div_res = (div_q_r > 48'h8000_0000) ? 32'sh8000_0000 : -$signed(div_q_r[31:0]);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    best_nxt  = best_r;
    m_nxt     = m_r;
    bm_nxt    = bm_r;
    bs_nxt    = bs_r;
    cm_nxt    = cm_r;
    cs_nxt    = cs_r;
    r_nxt     = r_r;
    pr_nxt    = pr_r;
    tmp_nxt   = tmp_r;
    pv_nxt    = pv_r;
    f_nxt     = f_r;
    b_nxt     = b_r;
    s_nxt     = s_r;
    prod1_nxt = prod1_r;
    code_nxt  = code_r;
    where_nxt = where_r;
    bwd_nxt   = bwd_r;
    a_we      = 1'b0;
    a_wrow    = r_r;
    a_wcol    = k_r[IW-1:0];
    a_wdata   = div_res;
    x_we      = 1'b0;
    x_wdata   = fw_val;
    scale_we  = 1'b0;
    rhs_we    = 1'b0;
    out_load  = 1'b0;
    out_item_nxt = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.mode)
            MODE_MAT: begin
              a_we    = (32'(in_data.row) < 32'(MAX_ORDER)) &&
                        (32'(in_data.col) < 32'(MAX_ORDER));
              a_wrow  = IW'(in_data.row);
              a_wcol  = IW'(in_data.col);
              a_wdata = in_data.value;
            end
            MODE_RHS: rhs_we = (32'(in_data.row) < 32'(MAX_ORDER));
            MODE_SOLVE: begin
              n_nxt     = n_start;
              i_nxt     = '0;
              j_nxt     = '0;
              m_nxt     = '0;
              state_nxt = S_SC_RD;
            end
            default: ;
          endcase
        end
      end

      // row scales
      S_SC_RD: state_nxt = S_SC_USE;
      S_SC_USE: begin
        m_nxt = m_cand;
        if (j_inc == n_r) begin
          if (m_cand == '0) begin
            code_nxt  = ST_ZERO_ROW;
            where_nxt = 5'(i_r);
            state_nxt = S_FAIL;
          end else begin
            scale_we = 1'b1;
            m_nxt    = '0;
            j_nxt    = '0;
            i_nxt    = i_inc;
            if (i_inc == n_r) begin
              k_nxt     = '0;
              state_nxt = (n_r == CW'(1)) ? S_FP_RD : S_PV_RD;
            end else begin
              state_nxt = S_SC_RD;
            end
          end
        end else begin
          j_nxt     = j_inc;
          state_nxt = S_SC_RD;
        end
      end

      // pivot search
      S_PV_RD: state_nxt = S_PV_USE;
      S_PV_USE: begin
        bm_nxt    = magn(a_rd_r);
        bs_nxt    = scale_rd_r;
        best_nxt  = k_r;
        i_nxt     = k_inc;
        state_nxt = S_CD_RD;
      end
      S_CD_RD: state_nxt = S_CD_M1;
      S_CD_M1: begin
        cm_nxt    = magn(a_rd_r);
        cs_nxt    = scale_rd_r;
        state_nxt = S_CD_M2;
      end
      S_CD_M2: begin
        prod1_nxt = mul_r;
        state_nxt = S_CD_CMP;
      end
      S_CD_CMP: begin
        if (prod1_r > mul_r) begin
          best_nxt = i_r;
          bm_nxt   = cm_r;
          bs_nxt   = cs_r;
        end
        i_nxt     = i_inc;
        state_nxt = (i_inc < n_r) ? S_CD_RD : S_PV_CHK;
      end
      S_PV_CHK: begin
        if (bm_r == '0) begin
          code_nxt  = ST_ZERO_COL;
          where_nxt = 5'(k_r);
          state_nxt = S_FAIL;
        end else begin
          state_nxt = S_SW1;
        end
      end
      S_SW1: begin
        tmp_nxt   = piv_q;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        pr_nxt    = tmp_r;
        state_nxt = S_PK_RD;
      end
      S_PK_RD: state_nxt = S_PK_USE;
      S_PK_USE: begin
        pv_nxt    = a_rd_r;
        i_nxt     = k_inc;
        state_nxt = S_EL_RD;
      end

      // row elimination
      S_EL_RD: begin
        r_nxt     = piv_q;
        state_nxt = S_EL_DIV;
      end
      S_EL_DIV: state_nxt = S_EL_DW;
      S_EL_DW: begin
        if (div_cnt_r == '0) begin
          a_we      = 1'b1;
          f_nxt     = div_res;
          j_nxt     = k_inc;
          state_nxt = S_EU_RD;
        end
      end
      S_EU_RD: state_nxt = S_EU_M;
      S_EU_M:  state_nxt = S_EU_RD2;
      S_EU_RD2: begin
        prod1_nxt = qprod(mul_r);
        state_nxt = S_EU_WR;
      end
      S_EU_WR: begin
        a_we    = 1'b1;
        a_wcol  = j_r[IW-1:0];
        a_wdata = eu_val;
        if (j_inc < n_r) begin
          j_nxt     = j_inc;
          state_nxt = S_EU_RD;
        end else if (i_inc < n_r) begin
          i_nxt     = i_inc;
          state_nxt = S_EL_RD;
        end else begin
          k_nxt     = k_inc;
          state_nxt = ((k_inc + CW'(1)) < n_r) ? S_PV_RD : S_FP_RD;
        end
      end

      // final pivot check
      S_FP_RD: state_nxt = S_FP_USE;
      S_FP_USE: begin
        if (a_rd_r == '0) begin
          code_nxt  = ST_ZERO_PIVOT;
          where_nxt = 5'(n_r);
          state_nxt = S_FAIL;
        end else begin
          k_nxt     = '0;
          bwd_nxt   = 1'b0;
          state_nxt = S_FW_RD;
        end
      end

      // forward substitution
      S_FW_RD: begin
        r_nxt     = piv_q;
        s_nxt     = '0;
        j_nxt     = '0;
        state_nxt = S_FW_RHS;
      end
      S_FW_RHS: begin
        b_nxt     = rhs_rd_r;
        state_nxt = (k_r == '0) ? S_FW_WR : S_SUM_RD;
      end

      // shared dot product over j
      S_SUM_RD: state_nxt = S_SUM_M;
      S_SUM_M:  state_nxt = S_SUM_AC;
      S_SUM_AC: begin
        s_nxt = s_r + qprod(mul_r);
        j_nxt = j_inc;
        if (j_inc < (bwd_r ? n_r : k_r)) state_nxt = S_SUM_RD;
        else state_nxt = bwd_r ? S_BW_DG : S_FW_WR;
      end

      S_FW_WR: begin
        x_we = 1'b1;
        if (k_inc == n_r) begin
          k_nxt     = nm1;
          bwd_nxt   = 1'b1;
          state_nxt = S_BW_RD;
        end else begin
          k_nxt     = k_inc;
          state_nxt = S_FW_RD;
        end
      end

      // back substitution
      S_BW_RD: begin
        r_nxt     = piv_q;
        state_nxt = S_BW_X;
      end
      S_BW_X: begin
        b_nxt     = x_rd_r;
        s_nxt     = '0;
        j_nxt     = k_inc;
        state_nxt = (k_inc < n_r) ? S_SUM_RD : S_BW_DG;
      end
      S_BW_DG:  state_nxt = S_BW_DIV;
      S_BW_DIV: state_nxt = S_BW_DW;
      S_BW_DW: begin
        if (div_cnt_r == '0) begin
          x_we    = 1'b1;
          x_wdata = div_res;
          if (k_r == '0) begin
            state_nxt = S_EM_RD;
          end else begin
            k_nxt     = k_r - CW'(1);
            state_nxt = S_BW_RD;
          end
        end
      end

      // result words
      S_EM_RD: state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        out_item_nxt.status         = ST_OK;
        out_item_nxt.sol_index      = 4'(k_r);
        out_item_nxt.solution_value = x_rd_r;
        out_item_nxt.last           = (k_inc == n_r);
        if (out_free) begin
          out_load = 1'b1;
          if (k_inc == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_EM_RD;
          end
        end
      end
      S_FAIL: begin
        out_item_nxt.status     = code_r;
        out_item_nxt.fail_index = where_r;
        out_item_nxt.last       = 1'b1;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= ORDER_W'(16);
      out_valid_r <= 1'b0;
      for (int q = 0; q < MAX_ORDER; q++) begin
        piv_r[q] <= IW'(q);
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_SC_USE) begin
        piv_r[i_r[IW-1:0]] <= i_r[IW-1:0];
      end
      if (state_r == S_SW2) begin
        piv_r[best_r[IW-1:0]] <= piv_q;
        piv_r[k_r[IW-1:0]]    <= tmp_r;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    best_r  <= best_nxt;
    m_r     <= m_nxt;
    bm_r    <= bm_nxt;
    bs_r    <= bs_nxt;
    cm_r    <= cm_nxt;
    cs_r    <= cs_nxt;
    r_r     <= r_nxt;
    pr_r    <= pr_nxt;
    tmp_r   <= tmp_nxt;
    pv_r    <= pv_nxt;
    f_r     <= f_nxt;
    b_r     <= b_nxt;
    s_r     <= s_nxt;
    prod1_r <= prod1_nxt;
    code_r  <= code_nxt;
    where_r <= where_nxt;
    bwd_r   <= bwd_nxt;
    if (out_load) begin
      out_data_r <= out_item_nxt;
    end
  end

  // matrix memory
  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[{a_wrow, a_wcol}] <= a_wdata;
    end
    a_rd_r <= a_mem[{a_rrow, a_rcol}];
  end

  // right-hand memory
  always_ff @(posedge clk) begin
    if (rhs_we) begin
      rhs_mem[IW'(in_data.row)] <= in_data.value;
    end
    rhs_rd_r <= rhs_mem[piv_q];
  end

  // row scale memory
  always_ff @(posedge clk) begin
    if (scale_we) begin
      scale_mem[i_r[IW-1:0]] <= m_cand;
    end
    scale_rd_r <= scale_mem[piv_q];
  end

  // solution memory
  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[k_r[IW-1:0]] <= x_wdata;
    end
    x_rd_r <= x_mem[x_raddr];
  end

  // checks
  `LUSP_ASSERT_NXT(a_div_load, state_r == S_EL_DIV, div_cnt_r == DCW'(DIV_STEPS), "divider not loaded")
  `LUSP_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(state_r == S_EM_OUT || state_r == S_FAIL), "result from wrong state")
  `LUSP_ASSERT_NXT(a_last_idle, out_load && out_item_nxt.last, state_r == S_IDLE, "no return to idle after last word")
  `LUSP_ASSERT_IMP(a_ok_index, out_valid_r && out_data_r.status == ST_OK, out_data_r.fail_index == 5'd0, "fail index on good result")

endmodule
`default_nettype wire
